// File: design/tcdb_pkg.sv
// Shared constants and register codes for the touch channel deglitch and baseline block.
package tcdb_pkg;

  // Fixed widths of the external fields
  localparam int OUT_W    = 20;
  localparam int SAMP_W   = 20;
  localparam int THR_W    = 20;
  localparam int WEIGHT_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int CNT_W    = 6;

  // Input action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_SEED   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SMOOTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_SMOOTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [WEIGHT_W-1:0] LEVEL_SMOOTH_RST    = 16'd0;
  localparam logic [WEIGHT_W-1:0] BASELINE_SMOOTH_RST = 16'd65208;
  localparam logic [THR_W-1:0]    THRESHOLD_RST       = 20'd0;

  // Glitch filter limits and counter ceiling
  localparam int GLITCH_NEAR = 5;
  localparam int GLITCH_FAR  = 3;
  localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

endpackage

// File: design/touch_channel_deglitch_baseline_core.sv
// Top level: capacitive touch deglitch, exponential smoothing and baseline tracking.
//
// Usage:
//   Input channel (in_valid/in_ready): each transaction carries in_action and
//   in_sample_value. Action ACT_SEED loads the history, the smoothed level and
//   the baseline with the calibration average; ACT_SAMPLE filters a raw reading.
//   Output channel (out_valid/out_ready): one transaction per input transaction,
//   out_touch_level = integer part of (smoothed - baseline), 0 when negative,
//   below touch_threshold, or on a seed.
//   Configuration (cfg_we/cfg_index/cfg_wdata): write only while the block is idle.
// Stages: input register, then the state update with its two multiply-accumulates per
//   average, then the result register that takes the difference and threshold compare.
// Throughput: one transaction per cycle while out_ready is high; the three stages
//   advance independently so a new one is taken while a result waits in the output.
// Reset: synchronous, active low; clears all history, levels, the sample count,
//   the valid flags and loads the register defaults.
// Stall: when out_ready is low the output holds, the stages behind it fill, and
//   in_ready drops once all three are occupied.
module touch_channel_deglitch_baseline_core #(
  parameter int SAMPLE_BITS    = 20,
  parameter int FRACTION_BITS  = 16,
  parameter int BASELINE_DELAY = 50
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_action,
  input  logic [tcdb_pkg::SAMP_W-1:0]      in_sample_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tcdb_pkg::OUT_W-1:0]       out_touch_level,
  input  logic                             cfg_we,
  input  logic [tcdb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcdb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tcdb_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int LW = SB + FB;                    // level width, FB fraction bits
  localparam int MW = LW + 18;                    // blend accumulator width
  localparam int CW = (SB > THR_W) ? SB : THR_W;  // difference compare width
  localparam logic [7:0] DELAY_L = 8'(BASELINE_DELAY);

  // floor((x * 2^FB * (1 - w) + lvl * w)), weights in Q0.16
  function automatic logic [LW-1:0] blend(input logic [SB-1:0] x,
                                           input logic [LW-1:0] lvl,
                                           input logic [WEIGHT_W-1:0] w);
    logic [WEIGHT_W:0]    wo;
    logic [SB+WEIGHT_W:0] xw;
    logic [LW+15:0]       lv;
    logic [MW-1:0]        acc;
    wo  = 17'h10000 - {1'b0, w};
    xw  = x * wo;
    lv  = lvl * w;
    acc = (MW'(xw) << FB) + MW'(lv);
    return acc[LW+15:16];
  endfunction

  // Configuration registers
  logic [WEIGHT_W-1:0] lvl_w_r;
  logic [WEIGHT_W-1:0] bl_w_r;
  logic [THR_W-1:0]    thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_w_r <= LEVEL_SMOOTH_RST;
      bl_w_r  <= BASELINE_SMOOTH_RST;
      thr_r   <= THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVEL_SMOOTH:    lvl_w_r <= cfg_wdata[WEIGHT_W-1:0];
        REG_BASELINE_SMOOTH: bl_w_r  <= cfg_wdata[WEIGHT_W-1:0];
        REG_TOUCH_THRESHOLD: thr_r   <= cfg_wdata[THR_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Handshake chain: each stage moves when the one ahead is free or leaving
  logic s0_vld_r, s1_vld_r, out_vld_r;
  logic out_free, s1_free, s0_free, s0_adv, s1_adv, in_acc;

  assign out_free = !out_vld_r || out_ready;
  assign s1_adv   = s1_vld_r && out_free;
  assign s1_free  = !s1_vld_r || out_free;
  assign s0_adv   = s0_vld_r && s1_free;
  assign s0_free  = !s0_vld_r || s1_free;
  assign in_ready = s0_free;
  assign in_acc   = in_valid && s0_free;

  // Stage 0: input register
  logic          s0_act_r;
  logic [SB-1:0] s0_samp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_free) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_act_r  <= in_action;
      s0_samp_r <= SB'(in_sample_value);
    end
  end

  // Stage 1: filter state; the result register reads the result of an item from it
  logic [SB-1:0]    mid_r, mid_nxt;
  logic [SB-1:0]    old_r, old_nxt;
  logic [LW-1:0]    sm_r, sm_nxt;
  logic [LW-1:0]    bl_r, bl_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SB-1:0]    near_d, far_d;
  logic             glitch;

  always_comb begin
    near_d  = (old_r > s0_samp_r) ? old_r - s0_samp_r : s0_samp_r - old_r;
    far_d   = (mid_r > old_r) ? mid_r - old_r : old_r - mid_r;
    glitch  = (near_d < SB'(GLITCH_NEAR)) && (far_d > SB'(GLITCH_FAR));
    mid_nxt = mid_r;
    old_nxt = old_r;
    sm_nxt  = sm_r;
    bl_nxt  = bl_r;
    cnt_nxt = cnt_r;
    if (s0_act_r == ACT_SEED) begin
      mid_nxt = s0_samp_r;
      old_nxt = s0_samp_r;
      sm_nxt  = LW'(s0_samp_r) << FB;
      bl_nxt  = LW'(s0_samp_r) << FB;
      cnt_nxt = '0;
    end else begin
      // Replace an isolated middle sample, then shift the history
      old_nxt = glitch ? old_r : mid_r;
      mid_nxt = s0_samp_r;
      sm_nxt  = blend(old_r, sm_r, lvl_w_r);
      if ({2'b00, cnt_r} > DELAY_L) begin
        bl_nxt = blend(old_r, bl_r, bl_w_r);
      end
      if (cnt_r != CNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      mid_r    <= '0;
      old_r    <= '0;
      sm_r     <= '0;
      bl_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (s1_free) begin
        s1_vld_r <= s0_vld_r;
      end
      if (s0_adv) begin
        mid_r <= mid_nxt;
        old_r <= old_nxt;
        sm_r  <= sm_nxt;
        bl_r  <= bl_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Stage 2: result register; difference, fraction drop and threshold
  logic [LW-1:0]    diff_full;
  logic [CW-1:0]    diff_ext;
  logic [OUT_W-1:0] lvl_out_r, lvl_out_nxt;

  always_comb begin
    diff_full   = sm_r - bl_r;
    diff_ext    = CW'(diff_full[LW-1:FB]);
    lvl_out_nxt = '0;
    if ((sm_r > bl_r) && !(diff_ext < CW'(thr_r))) begin
      lvl_out_nxt = diff_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      lvl_out_r <= lvl_out_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_touch_level = lvl_out_r;

  // A seed leaves the smoothed level equal to the baseline
  a_seed_equal: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv && (s0_act_r == ACT_SEED) |=> sm_r == bl_r)
    else $error("seed did not align smoothed level and baseline");

  // The baseline holds until the sample count passes the delay
  a_bl_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv && (s0_act_r == ACT_SAMPLE) && ({2'b00, cnt_r} <= DELAY_L) |=> $stable(bl_r))
    else $error("baseline moved before the delay elapsed");

  // A raw sample advances the count by one or leaves it at its ceiling
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv && (s0_act_r == ACT_SAMPLE)
      |=> (cnt_r == $past(cnt_r) + 6'd1) || (cnt_r == CNT_MAX))
    else $error("sample count stepped wrongly");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the touch channel deglitch and baseline tracking core.
module testbench;
  import tcdb_pkg::*;

  localparam int BASELINE_DELAY = 50;
  localparam int RANDOM_ITEMS   = 1350;
  // Cycles without any transaction before the run is declared hung
  localparam int HANG_LIMIT     = 2000;
  // Cycles to let the pipeline empty out once nothing is pending
  localparam int DRAIN_CYCLES   = 4;
  localparam logic [SAMP_W-1:0] SAMP_MAX = '1;
  localparam logic [THR_W-1:0]  THR_MAX  = '1;

  // Receiver behavior modes
  localparam logic [1:0] RX_ALWAYS  = 2'd0;
  localparam logic [1:0] RX_RANDOM  = 2'd1;
  localparam logic [1:0] RX_PATTERN = 2'd2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_action;
  logic [SAMP_W-1:0]     in_sample_value;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_W-1:0]      out_touch_level;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  touch_channel_deglitch_baseline_core #(
    .SAMPLE_BITS(SAMP_W),
    .FRACTION_BITS(16),
    .BASELINE_DELAY(BASELINE_DELAY)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_sample_value(in_sample_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_touch_level(out_touch_level),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Channel model: history, the two averages and the saturating sample count,
  // plus a mirror of the three registers as last written.
  // ---------------------------------------------------------------------------
  logic [SAMP_W-1:0]   hist_middle = '0;
  logic [SAMP_W-1:0]   hist_oldest = '0;
  logic [SAMP_W+15:0]  smooth_acc  = '0;
  logic [SAMP_W+15:0]  base_acc    = '0;
  logic [CNT_W-1:0]    seen_count  = '0;
  logic [WEIGHT_W-1:0] level_weight    = LEVEL_SMOOTH_RST;
  logic [WEIGHT_W-1:0] baseline_weight = BASELINE_SMOOTH_RST;
  logic [THR_W-1:0]    threshold_level = THRESHOLD_RST;

  // Touch levels still owed by the block, oldest first
  logic [OUT_W-1:0] level_queue[$];
  int               error_count = 0;
  int               burst_left  = 0;

  // Move a Q.16 level toward x with weight w on the old level; truncate the fraction.
  function automatic logic [SAMP_W+15:0] blend_toward(input logic [SAMP_W-1:0] x,
                                                       input logic [SAMP_W+15:0] lvl,
                                                       input logic [WEIGHT_W-1:0] w);
    logic [63:0] acc;
    acc = ({44'd0, x} << 16) * (64'd65536 - {48'd0, w}) + {28'd0, lvl} * {48'd0, w};
    return acc[SAMP_W+31:16];
  endfunction

  // Apply one transaction to the channel model and return the touch level it yields.
  function automatic logic [OUT_W-1:0] advance_channel(input logic act,
                                                       input logic [SAMP_W-1:0] val);
    logic [SAMP_W-1:0]  near_gap;
    logic [SAMP_W-1:0]  far_gap;
    logic [SAMP_W+15:0] span;
    logic [OUT_W-1:0]   level;
    if (act == ACT_SEED) begin
      hist_middle = val;
      hist_oldest = val;
      smooth_acc  = {val, 16'h0000};
      base_acc    = {val, 16'h0000};
      seen_count  = '0;
      return '0;
    end
    // Replace a lone middle sample that jumped away while the newest came back
    near_gap = (hist_oldest > val) ? hist_oldest - val : val - hist_oldest;
    far_gap  = (hist_middle > hist_oldest) ? hist_middle - hist_oldest
                                           : hist_oldest - hist_middle;
    if (near_gap < GLITCH_NEAR && far_gap > GLITCH_FAR)
      hist_middle = hist_oldest;
    smooth_acc = blend_toward(hist_oldest, smooth_acc, level_weight);
    // The count is tested before it advances
    if (seen_count > BASELINE_DELAY)
      base_acc = blend_toward(hist_oldest, base_acc, baseline_weight);
    if (seen_count < CNT_MAX)
      seen_count = seen_count + 1'b1;
    hist_oldest = hist_middle;
    hist_middle = val;
    if (smooth_acc <= base_acc)
      return '0;
    span  = smooth_acc - base_acc;
    level = span[SAMP_W+15:16];
    if (level < threshold_level)
      return '0;
    return level;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
    $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps; some bursts run
  // long with no gap at all. Enter and leave on a rising edge.
  // ---------------------------------------------------------------------------
  task automatic push_reading(input logic act, input logic [SAMP_W-1:0] val);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 150);
      end else begin
        burst_left = $urandom_range(1, 30);
        gap = $urandom_range(1, 12);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    // Hold valid and payload until the transaction is taken
    in_valid        <= 1'b1;
    in_action       <= act;
    in_sample_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    level_queue.push_back(advance_channel(act, val));
  endtask

  // Drop valid, wait for every owed result, then let the pipeline run dry.
  task automatic settle();
    in_valid <= 1'b0;
    while (level_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back while the block is idle.
  task automatic configure(input logic [WEIGHT_W-1:0] lvl_w,
                           input logic [WEIGHT_W-1:0] base_w,
                           input logic [THR_W-1:0] thr);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_LEVEL_SMOOTH;
    cfg_wdata <= CFG_DATA_W'(lvl_w);
    @(posedge clk);
    cfg_index <= REG_BASELINE_SMOOTH;
    cfg_wdata <= CFG_DATA_W'(base_w);
    @(posedge clk);
    cfg_index <= REG_TOUCH_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    level_weight    = lvl_w;
    baseline_weight = base_w;
    threshold_level = thr;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: switch between always ready, random stalls and a repeating
  // 16-bit mask. Keep bit 0 of the mask set so a stall never lasts forever.
  // ---------------------------------------------------------------------------
  logic [1:0]  rx_mode  = RX_ALWAYS;
  int          rx_left  = 0;
  logic [15:0] rx_mask  = 16'h0001;
  logic [3:0]  rx_phase = '0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = 2'($urandom_range(0, 2));
      rx_left = $urandom_range(32, 256);
      rx_mask = 16'($urandom) | 16'h0001;
    end else begin
      rx_left--;
    end
    rx_phase = rx_phase + 1'b1;
    case (rx_mode)
      RX_ALWAYS: begin
        out_ready <= 1'b1;
      end
      RX_RANDOM: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready <= rx_mask[rx_phase];
      end
    endcase
  end

  // Compare every accepted result with the oldest owed touch level.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (level_queue.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_touch_level);
      end else begin
        if (out_touch_level !== level_queue[0])
          report_mismatch("touch_level", level_queue[0], out_touch_level);
        void'(level_queue.pop_front());
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset weights: level follows the oldest sample exactly, baseline is frozen at
  // zero, so a full-scale reading must come out as the largest touch level.
  task automatic test_reset_defaults();
    push_reading(ACT_SAMPLE, SAMP_MAX);
    push_reading(ACT_SAMPLE, SAMP_MAX);
    push_reading(ACT_SAMPLE, '0);
    push_reading(ACT_SAMPLE, '0);
  endtask

  // A seed loads everything with the calibration value and reports zero.
  task automatic test_seed_load();
    push_reading(ACT_SEED, SAMP_MAX);
    push_reading(ACT_SAMPLE, '0);
    push_reading(ACT_SEED, '0);
  endtask

  // One removal, then the two boundaries where the filter must stay out.
  task automatic test_glitch_filter();
    push_reading(ACT_SEED, 20'd1000);
    push_reading(ACT_SAMPLE, 20'd1010);
    push_reading(ACT_SAMPLE, 20'd1004);
    // middle off by exactly the far limit: not a glitch
    push_reading(ACT_SEED, 20'd2000);
    push_reading(ACT_SAMPLE, 20'd2003);
    push_reading(ACT_SAMPLE, 20'd2004);
    // newest off by exactly the near limit: not a glitch
    push_reading(ACT_SEED, 20'd3000);
    push_reading(ACT_SAMPLE, 20'd3010);
    push_reading(ACT_SAMPLE, 20'd3005);
  endtask

  // Largest threshold: a full-scale difference equals it and must still pass.
  task automatic test_threshold_edges();
    configure('0, '1, THR_MAX);
    push_reading(ACT_SEED, '0);
    push_reading(ACT_SAMPLE, SAMP_MAX);
    push_reading(ACT_SAMPLE, SAMP_MAX);
    push_reading(ACT_SAMPLE, SAMP_MAX);
  endtask

  // Heaviest level weight: the oldest sample is still the seed, so the level stays zero.
  task automatic test_weight_extremes();
    configure('1, '0, '0);
    push_reading(ACT_SEED, '0);
    push_reading(ACT_SAMPLE, SAMP_MAX);
    push_reading(ACT_SAMPLE, SAMP_MAX);
  endtask

  // Calibrated runs: seed, then a noisy reading around the seed with touches
  // coming and going, lone spikes for the glitch filter, and a little garbage.
  // Some runs are long enough for the baseline to start tracking.
  task automatic test_random_tracking();
    int made;
    int base;
    int offset;
    int val;
    int run_len;
    int r;
    logic [WEIGHT_W-1:0] lvl_w;
    logic [WEIGHT_W-1:0] base_w;
    logic [THR_W-1:0]    thr;
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if (made == 0 || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0:       lvl_w = '0;
          1:       lvl_w = '1;
          2:       lvl_w = 16'($urandom_range(60000, 65535));
          default: lvl_w = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0:       base_w = '0;
          1:       base_w = '1;
          2:       base_w = BASELINE_SMOOTH_RST;
          default: base_w = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0:       thr = '0;
          1:       thr = THR_MAX;
          4:       thr = 20'($urandom);
          default: thr = 20'($urandom_range(0, 4000));
        endcase
        configure(lvl_w, base_w, thr);
      end
      case ($urandom_range(0, 4))
        0:       base = 0;
        1:       base = int'(SAMP_MAX);
        2:       base = $urandom_range(1000, 100000);
        default: base = $urandom_range(0, int'(SAMP_MAX));
      endcase
      offset = 0;
      push_reading(ACT_SEED, 20'(base));
      made++;
      run_len = $urandom_range(20, 160);
      for (int i = 0; i < run_len; i++) begin
        // Touch on, touch off, or a drop below the calibration level
        if ($urandom_range(0, 29) == 0) begin
          case ($urandom_range(0, 3))
            0:       offset = 0;
            1:       offset = -$urandom_range(50, 50000);
            default: offset = $urandom_range(50, 300000);
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
          push_reading(ACT_SAMPLE, 20'($urandom));
        end else if (r < 6) begin
          push_reading(ACT_SEED, 20'($urandom));
        end else begin
          val = base + offset + $urandom_range(0, 16) - 8;
          if (r < 14)
            val += ($urandom_range(0, 1) != 0) ? $urandom_range(4, 40) : -$urandom_range(4, 40);
          if (val < 0)
            val = 0;
          if (val > int'(SAMP_MAX))
            val = int'(SAMP_MAX);
          push_reading(ACT_SAMPLE, 20'(val));
        end
        made++;
      end
    end
  endtask

  initial begin
    in_valid        <= 1'b0;
    in_action       <= ACT_SAMPLE;
    in_sample_value <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_LEVEL_SMOOTH;
    cfg_wdata       <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_seed_load();
    test_glitch_filter();
    test_threshold_edges();
    test_weight_extremes();
    test_random_tracking();

    settle();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
